/* sv/skvt_pkg.sv */
// Shared constants and types for the sorted key/value table.
package skvt_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int REQ_W    = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 14;
    localparam int STAT_W   = 3;
    localparam int CNTO_W   = 8;

    localparam logic [VAL_W-1:0] VALUE_MAX = VAL_W'(10000);

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 3'd0,
        ST_DUP    = 3'd1,
        ST_ABSENT = 3'd2,
        ST_FULL   = 3'd3,
        ST_EMPTY  = 3'd4
    } t_status;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value;
    } t_entry;

endpackage

/* sv/skvt_if.sv */
// Request and response channel interfaces for the sorted key/value table.
interface skvt_req_if
    import skvt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value_in;

    modport source (output valid, output req_type, output key, output value_in, input ready);
    modport sink   (input valid, input req_type, input key, input value_in, output ready);
endinterface

interface skvt_rsp_if
    import skvt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value_out;
    logic [CNTO_W-1:0] count_out;

    modport source (output valid, output status, output value_out, output count_out, input ready);
    modport sink   (input valid, input status, input value_out, input count_out, output ready);
endinterface

/* sv/sorted_key_value_table.sv */
// Sorted key/value table: sequencer over one table memory, linear search and shifts.
//
//   channel  dir  transaction                     handshake
//   i_req    in   req_type, key, value_in         valid/ready
//   o_rsp    out  status, value_out, count_out    valid/ready
//
// One transaction at a time: i_req.ready is high only while idle with no pending response.
// Search walks the table one entry per cycle from slot 0 through the single read port.
// Insert then shifts later entries up one slot per cycle, remove shifts them down.
// Synchronous reset empties the table at once; memory contents are not cleared.
// A stalled response holds its register; the next request waits until it is taken.
module sorted_key_value_table
    import skvt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    skvt_req_if.sink   i_req,
    skvt_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHUP,
        S_PUT,
        S_SHDN
    } t_state;

    t_state            r_state,     n_state;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [VAL_W-1:0]  r_out_value, n_out_value;
    logic [CNTO_W-1:0] r_out_count, n_out_count;

    t_req              r_req,  n_req;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0]  r_val,  n_val;
    logic [CNT_W-1:0]  r_idx,  n_idx;
    logic [IDX_W-1:0]  r_pos,  n_pos;
    logic [IDX_W-1:0]  r_wptr, n_wptr;

    t_entry            mem [CAPACITY];
    t_entry            r_rd;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_entry            mem_wdata;
    logic [IDX_W-1:0]  rd_addr;

    logic              accept;
    logic              hit_end;
    logic              less;
    logic              match;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  cnt_dec;

    assign i_req.ready     = (r_state == S_IDLE) && !r_out_valid;
    assign accept          = i_req.valid && i_req.ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.value_out = r_out_value;
    assign o_rsp.count_out = r_out_count;

    assign hit_end = (r_idx == r_count);
    assign less    = r_rd.key < r_key;
    assign match   = !hit_end && (r_rd.key == r_key);
    assign cnt_inc = r_count + 1'b1;
    assign cnt_dec = r_count - 1'b1;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_count  = r_out_count;
        n_req        = r_req;
        n_key        = r_key;
        n_val        = r_val;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_wptr       = r_wptr;
        mem_we       = 1'b0;
        mem_waddr    = r_wptr;
        mem_wdata    = r_rd;
        rd_addr      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req = t_req'(i_req.req_type);
                    n_key = $signed(i_req.key);
                    n_val = (i_req.value_in > VALUE_MAX) ? VALUE_MAX : i_req.value_in;
                    n_idx = '0;
                    n_out_value = '0;
                    n_out_count = CNTO_W'(r_count);
                    priority if (t_req'(i_req.req_type) == REQ_NONE) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_DONE;
                    end else if (t_req'(i_req.req_type) == REQ_INSERT
                                 && r_count >= CNT_W'(CAPACITY)) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_FULL;
                    end else if (t_req'(i_req.req_type) != REQ_INSERT && r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (!hit_end && less) begin
                    n_idx   = r_idx + 1'b1;
                    rd_addr = IDX_W'(r_idx + 1'b1);
                end else begin
                    n_pos       = IDX_W'(r_idx);
                    n_out_value = '0;
                    n_out_count = CNTO_W'(r_count);
                    unique case (r_req)
                        REQ_SEARCH: begin
                            n_state      = S_IDLE;
                            n_out_valid  = 1'b1;
                            n_out_status = match ? ST_DONE : ST_ABSENT;
                            n_out_value  = match ? r_rd.value : '0;
                        end
                        REQ_INSERT: begin
                            priority if (match) begin
                                n_state      = S_IDLE;
                                n_out_valid  = 1'b1;
                                n_out_status = ST_DUP;
                            end else if (hit_end) begin
                                n_state = S_PUT;
                            end else begin
                                n_wptr  = IDX_W'(r_count);
                                rd_addr = IDX_W'(cnt_dec);
                                n_state = S_SHUP;
                            end
                        end
                        REQ_REMOVE: begin
                            priority if (!match) begin
                                n_state      = S_IDLE;
                                n_out_valid  = 1'b1;
                                n_out_status = ST_ABSENT;
                            end else if (r_idx + 1'b1 == r_count) begin
                                n_state      = S_IDLE;
                                n_count      = cnt_dec;
                                n_out_valid  = 1'b1;
                                n_out_status = ST_DONE;
                                n_out_count  = CNTO_W'(cnt_dec);
                            end else begin
                                n_wptr  = IDX_W'(r_idx);
                                rd_addr = IDX_W'(r_idx + 1'b1);
                                n_state = S_SHDN;
                            end
                        end
                        default: begin
                            n_state      = S_IDLE;
                            n_out_valid  = 1'b1;
                            n_out_status = ST_DONE;
                        end
                    endcase
                end
            end

            S_SHUP: begin
                mem_we    = 1'b1;
                mem_waddr = r_wptr;
                mem_wdata = r_rd;
                n_wptr    = r_wptr - 1'b1;
                rd_addr   = r_wptr - 2'd2;
                if (IDX_W'(r_wptr - 1'b1) == r_pos) begin
                    n_state = S_PUT;
                end
            end

            S_PUT: begin
                mem_we       = 1'b1;
                mem_waddr    = r_pos;
                mem_wdata    = '{key: r_key, value: r_val};
                n_count      = cnt_inc;
                n_state      = S_IDLE;
                n_out_valid  = 1'b1;
                n_out_status = ST_DONE;
                n_out_value  = '0;
                n_out_count  = CNTO_W'(cnt_inc);
            end

            S_SHDN: begin
                mem_we    = 1'b1;
                mem_waddr = r_wptr;
                mem_wdata = r_rd;
                n_wptr    = r_wptr + 1'b1;
                rd_addr   = r_wptr + 2'd2;
                if (CNT_W'(r_wptr) + 2'd2 >= r_count) begin
                    n_count      = cnt_dec;
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_DONE;
                    n_out_value  = '0;
                    n_out_count  = CNTO_W'(cnt_dec);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_count  <= n_out_count;
        r_req        <= n_req;
        r_key        <= n_key;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_wptr       <= n_wptr;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
